[hw/rtl/reb_pkg.sv]
// Shared constants, types and helper functions of the rectangular element basis evaluator.
`timescale 1ns / 1ps
`default_nettype none

package reb_pkg;

    // Number format and function counts.
    localparam int FRAC_BITS    = 16;
    localparam int VECTOR_FUNCS = 12;
    localparam int SCALAR_FUNCS = 4;

    // Divider geometry: 31 quotient bits, one per stage, plus entry and exit registers.
    localparam int QBITS    = 31;
    localparam int DIV_LAT  = QBITS + 2;
    localparam int NUM_W    = 35;
    localparam int DEN_W    = 34;
    localparam int REM_W    = 66;
    localparam int E_STAGES = 6;

    // Command codes.
    localparam logic [2:0] CMD_PHIX = 3'd0;
    localparam logic [2:0] CMD_PHIY = 3'd1;
    localparam logic [2:0] CMD_DXK  = 3'd2;
    localparam logic [2:0] CMD_DYE  = 3'd3;
    localparam logic [2:0] CMD_PSI  = 3'd4;

    // Fixed-point constants.
    localparam logic signed [33:0] ONE34   = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] QHALF32 = 32'sd1 <<< (FRAC_BITS - 1);
    localparam logic [QBITS-1:0]   MAG_MAX = {QBITS{1'b1}};
    localparam logic signed [63:0] MAX64   = 64'sd2147483647;
    localparam logic signed [63:0] MIN64   = -64'sd2147483648;

    // Evaluation recipe, chosen from command and basis index.
    typedef enum logic [3:0] {
        OP_ZERO,
        OP_CONST,
        OP_HALF,
        OP_MUL_HALF,
        OP_OMS,
        OP_OMS_MUL,
        OP_SHIFT,
        OP_M2P,
        OP_M2MUL,
        OP_PSI
    } op_t;

    // Saturated value with its clip flag.
    typedef struct packed {
        logic              clip;
        logic signed [31:0] val;
    } sat_t;

    // Item control that travels alongside the coordinate dividers.
    typedef struct packed {
        op_t                     op;
        logic                    swap;
        logic                    hi;
        logic                    neg;
        logic                    hik;
        logic                    hie;
        logic                    deriv;
        logic                    use_hy;
        logic                    bad;
        logic                    degen;
        logic signed [DEN_W-1:0] hx;
        logic signed [DEN_W-1:0] hy;
    } side_t;

    // State of one item in the evaluation stages.
    typedef struct packed {
        op_t                     op;
        logic                    deriv;
        logic                    use_hy;
        logic                    bad;
        logic                    degen;
        logic                    sat;
        logic signed [DEN_W-1:0] hx;
        logic signed [DEN_W-1:0] hy;
        logic signed [31:0]      s;
        logic signed [31:0]      ma;
        logic signed [31:0]      mb;
        logic signed [31:0]      lin;
        logic signed [63:0]      prod;
        logic signed [31:0]      m1;
        logic signed [31:0]      oms;
        logic signed [31:0]      m2x;
        logic signed [31:0]      m2;
    } ev_t;

    // Item state that travels alongside the derivative divider.
    typedef struct packed {
        logic               deriv;
        logic               bad;
        logic               degen;
        logic               sat;
        logic signed [31:0] val;
    } fin_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic sat_t sat64(input logic signed [63:0] v);
        sat_t r;
        if (v > MAX64) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end
        else if (v < MIN64) begin
            r.clip = 1'b1;
            r.val  = 32'sh80000000;
        end
        else begin
            r.clip = 1'b0;
            r.val  = 32'(v);
        end
        return r;
    endfunction

    // (1 - v) / 2, rounding toward minus infinity.
    function automatic logic signed [31:0] half_lo(input logic signed [31:0] v);
        logic signed [33:0] t;
        t = ONE34 - 34'(v);
        return 32'(t >>> 1);
    endfunction

    // (1 + v) / 2, rounding toward minus infinity.
    function automatic logic signed [31:0] half_hi(input logic signed [31:0] v);
        logic signed [33:0] t;
        t = ONE34 + 34'(v);
        return 32'(t >>> 1);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/reb_qdiv.sv]
// Pipelined signed fixed-point divider, one quotient bit per stage, clamped magnitude.
`timescale 1ns / 1ps
`default_nettype none

module reb_qdiv (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_vld,
    input  logic signed [reb_pkg::NUM_W-1:0] num,
    input  logic signed [reb_pkg::DEN_W-1:0] den,
    output logic                             out_vld,
    output logic signed [31:0]               quo,
    output logic                             clip
);
    import reb_pkg::*;

    logic [REM_W-1:0] rem_reg [0:QBITS];
    logic [QBITS-1:0] q_reg   [0:QBITS];
    logic [DEN_W-1:0] ad_reg  [0:QBITS];
    logic [QBITS:0]   neg_reg;
    logic [QBITS:0]   adz_reg;
    logic [QBITS:0]   clip_reg;
    logic [QBITS:0]   vld_reg;

    logic [REM_W-1:0] trial [1:QBITS];
    logic [QBITS:1]   ge;
    logic             clip_first;
    logic [NUM_W-1:0] an;
    logic [DEN_W-1:0] ad_in;
    logic [QBITS-1:0] mag;

    logic               out_vld_reg;
    logic signed [31:0] out_quo_reg;
    logic               out_clip_reg;

    // Magnitudes of the operands.
    always_comb
    begin
        an    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        ad_in = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    end

    // Trial subtraction of each stage, and the overflow test at the first stage.
    always_comb
    begin
        for (int k = 1; k <= QBITS; k++)
        begin
            trial[k] = REM_W'(ad_reg[k-1]) << (QBITS - k);
            ge[k]    = rem_reg[k-1] >= trial[k];
        end
        clip_first = rem_reg[0] >= (REM_W'(ad_reg[0]) << QBITS);
    end

    // Final magnitude: clamped on overflow, zero for a zero divisor.
    always_comb
    begin
        if (adz_reg[QBITS])
            mag = '0;
        else if (clip_reg[QBITS])
            mag = MAG_MAX;
        else
            mag = q_reg[QBITS];
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= QBITS; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_vld_reg <= vld_reg[QBITS];
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= REM_W'(an) << FRAC_BITS;
            q_reg[0]    <= '0;
            ad_reg[0]   <= ad_in;
            neg_reg[0]  <= num[NUM_W-1] ^ den[DEN_W-1];
            adz_reg[0]  <= (den == '0);
            clip_reg[0] <= 1'b0;
            for (int k = 1; k <= QBITS; k++)
            begin
                rem_reg[k]  <= ge[k] ? rem_reg[k-1] - trial[k] : rem_reg[k-1];
                q_reg[k]    <= q_reg[k-1] | (ge[k] ? (QBITS'(1) << (QBITS - k)) : '0);
                ad_reg[k]   <= ad_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                adz_reg[k]  <= adz_reg[k-1];
                clip_reg[k] <= (k == 1) ? clip_first : clip_reg[k-1];
            end
            out_quo_reg  <= neg_reg[QBITS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            out_clip_reg <= clip_reg[QBITS] & ~adz_reg[QBITS];
        end
    end

    assign out_vld = out_vld_reg;
    assign quo     = out_quo_reg;
    assign clip    = out_clip_reg;

endmodule

`default_nettype wire

[hw/rtl/rect_element_basis_eval.sv]
// Top level of the rectangular element basis evaluator pipeline.
//
// The block takes one item per clock and returns one result per item, in order. An
// entry stage forms the element widths and centered coordinates, a pair of bit-per-stage
// dividers produce ksi and etta, six evaluation stages hold two registered 32x32
// multipliers, a bit-per-stage divider scales derivatives by the element width, and one
// output register holds the result. A stall on the result side holds the whole pipeline,
// so in_stall follows out_stall while a result waits. All values are signed Q16.16;
// saturation, degenerate elements and bad indexes are flagged with the result.
`timescale 1ns / 1ps
`default_nettype none

module rect_element_basis_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [3:0]         basis_index,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] left_edge,
    input  logic signed [31:0] right_edge,
    input  logic signed [31:0] bottom_edge,
    input  logic signed [31:0] top_edge,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] basis_value,
    output logic               degenerate,
    output logic               bad_index,
    output logic               saturated
);
    import reb_pkg::*;

    logic adv;

    side_t                   p_side_next, p_side_reg;
    logic signed [NUM_W-1:0] p_nx_next, p_nx_reg, p_ny_next, p_ny_reg;
    logic                    p_vld_reg;
    logic [3:0]              sub_idx;

    side_t sd_reg [0:DIV_LAT-1];

    logic               d1x_vld, d1x_clip, d1y_vld, d1y_clip;
    logic signed [31:0] d1x_quo, d1y_quo;

    ev_t                 e_next [1:E_STAGES];
    ev_t                 e_reg  [1:E_STAGES];
    logic [E_STAGES:1]   e_vld_reg;

    fin_t                    f_next;
    fin_t                    f_reg [0:DIV_LAT-1];
    logic signed [NUM_W-1:0] d2_num;
    logic signed [DEN_W-1:0] d2_den;
    logic                    d2_vld, d2_clip;
    logic signed [31:0]      d2_quo;

    logic               out_vld_reg;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               out_degen_reg, out_bad_reg, out_sat_reg, out_sat_next;

    // The pipeline moves unless a result waits at a stalled output.
    assign adv      = ~(out_vld_reg & out_stall);
    assign in_stall = ~adv;

    // Entry stage: widths, centered coordinates, checks and evaluation recipe.
    always_comb
    begin
        p_side_next        = '0;
        p_side_next.hx     = DEN_W'(right_edge) - DEN_W'(left_edge);
        p_side_next.hy     = DEN_W'(top_edge) - DEN_W'(bottom_edge);
        p_nx_next          = (NUM_W'(point_x) <<< 1) - NUM_W'(left_edge) - NUM_W'(right_edge);
        p_ny_next          = (NUM_W'(point_y) <<< 1) - NUM_W'(bottom_edge) - NUM_W'(top_edge);
        p_side_next.degen  = (right_edge == left_edge) || (top_edge == bottom_edge);
        p_side_next.bad    = (command > CMD_PSI) ||
                             ((command == CMD_PSI) ? (basis_index >= 4'(SCALAR_FUNCS))
                                                   : (basis_index >= 4'(VECTOR_FUNCS)));
        p_side_next.swap   = (command == CMD_PHIY) || (command == CMD_DYE);
        p_side_next.deriv  = (command == CMD_DXK) || (command == CMD_DYE);
        p_side_next.use_hy = (command == CMD_DYE);
        p_side_next.hik    = basis_index[0];
        p_side_next.hie    = basis_index[1];
        sub_idx            = p_side_next.swap ? basis_index - 4'd2 : basis_index;
        p_side_next.hi     = sub_idx[0];
        p_side_next.neg    = ~sub_idx[0];
        p_side_next.op     = OP_ZERO;
        case (command)
            CMD_PHIX, CMD_PHIY:
            begin
                case (sub_idx)
                    4'd0, 4'd1: p_side_next.op = OP_HALF;
                    4'd4, 4'd5: p_side_next.op = OP_MUL_HALF;
                    4'd8:       p_side_next.op = OP_OMS;
                    4'd9:       p_side_next.op = OP_OMS_MUL;
                    default:    p_side_next.op = OP_ZERO;
                endcase
            end
            CMD_DXK, CMD_DYE:
            begin
                case (sub_idx)
                    4'd0, 4'd1: p_side_next.op = OP_CONST;
                    4'd4, 4'd5: p_side_next.op = OP_SHIFT;
                    4'd8:       p_side_next.op = OP_M2P;
                    4'd9:       p_side_next.op = OP_M2MUL;
                    default:    p_side_next.op = OP_ZERO;
                endcase
            end
            CMD_PSI: p_side_next.op = OP_PSI;
            default: p_side_next.op = OP_ZERO;
        endcase
    end

    // Reference coordinate dividers.
    reb_qdiv u_div_ksi (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (p_vld_reg),
        .num     (p_nx_reg),
        .den     (p_side_reg.hx),
        .out_vld (d1x_vld),
        .quo     (d1x_quo),
        .clip    (d1x_clip)
    );

    reb_qdiv u_div_etta (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (p_vld_reg),
        .num     (p_ny_reg),
        .den     (p_side_reg.hy),
        .out_vld (d1y_vld),
        .quo     (d1y_quo),
        .clip    (d1y_clip)
    );

    // First evaluation stage: operands of the first product and the direct values.
    always_comb
    begin : e1_calc
        side_t              sd;
        logic signed [31:0] pv, sv, hp, hk, he;
        logic signed [32:0] sx;
        logic               pc, sc, rd_p, rd_s;
        sat_t               m2p;

        sd   = sd_reg[DIV_LAT-1];
        pv   = sd.swap ? d1y_quo : d1x_quo;
        sv   = sd.swap ? d1x_quo : d1y_quo;
        pc   = sd.swap ? d1y_clip : d1x_clip;
        sc   = sd.swap ? d1x_clip : d1y_clip;
        hp   = sd.hi ? half_hi(pv) : half_lo(pv);
        hk   = sd.hik ? half_hi(d1x_quo) : half_lo(d1x_quo);
        he   = sd.hie ? half_hi(d1y_quo) : half_lo(d1y_quo);
        sx   = sd.neg ? -33'(sv) : 33'(sv);
        m2p  = sat64(-(64'(pv) <<< 1));
        rd_p = 1'b0;
        rd_s = 1'b0;

        e_next[1]        = '0;
        e_next[1].op     = sd.op;
        e_next[1].deriv  = sd.deriv;
        e_next[1].use_hy = sd.use_hy;
        e_next[1].bad    = sd.bad;
        e_next[1].degen  = sd.degen;
        e_next[1].hx     = sd.hx;
        e_next[1].hy     = sd.hy;
        e_next[1].s      = sv;

        case (sd.op)
            OP_CONST:
                e_next[1].lin = sd.neg ? -QHALF32 : QHALF32;
            OP_HALF:
            begin
                e_next[1].lin = hp;
                rd_p          = 1'b1;
            end
            OP_MUL_HALF:
            begin
                e_next[1].ma = hp;
                e_next[1].mb = sv;
                rd_p         = 1'b1;
                rd_s         = 1'b1;
            end
            OP_OMS:
            begin
                e_next[1].ma = pv;
                e_next[1].mb = pv;
                rd_p         = 1'b1;
            end
            OP_OMS_MUL:
            begin
                e_next[1].ma = pv;
                e_next[1].mb = pv;
                rd_p         = 1'b1;
                rd_s         = 1'b1;
            end
            OP_SHIFT:
            begin
                e_next[1].lin = 32'(sx >>> 1);
                rd_s          = 1'b1;
            end
            OP_M2P:
            begin
                e_next[1].lin = m2p.val;
                e_next[1].sat = m2p.clip;
                rd_p          = 1'b1;
            end
            OP_M2MUL:
            begin
                e_next[1].ma = pv;
                e_next[1].mb = sv;
                rd_p         = 1'b1;
                rd_s         = 1'b1;
            end
            OP_PSI:
            begin
                e_next[1].ma = hk;
                e_next[1].mb = he;
                rd_p         = 1'b1;
                rd_s         = 1'b1;
            end
            default:
                e_next[1].lin = '0;
        endcase
        e_next[1].sat = e_next[1].sat | (rd_p & pc) | (rd_s & sc);
    end

    // Later evaluation stages: two products, each scaled, with 1 - m1 and -2*m1 between.
    always_comb
    begin : e_rest
        sat_t m1s, omss, m2xs, m2s;

        e_next[2]      = e_reg[1];
        e_next[2].prod = 64'($signed(e_reg[1].ma)) * 64'($signed(e_reg[1].mb));

        m1s           = sat64($signed(e_reg[2].prod) >>> FRAC_BITS);
        e_next[3]     = e_reg[2];
        e_next[3].m1  = m1s.val;
        e_next[3].sat = e_reg[2].sat | m1s.clip;

        omss           = sat64(64'(ONE34) - 64'($signed(e_reg[3].m1)));
        m2xs           = sat64(-(64'($signed(e_reg[3].m1)) <<< 1));
        e_next[4]      = e_reg[3];
        e_next[4].oms  = omss.val;
        e_next[4].m2x  = m2xs.val;
        e_next[4].sat  = e_reg[3].sat |
                         (omss.clip & ((e_reg[3].op == OP_OMS) || (e_reg[3].op == OP_OMS_MUL))) |
                         (m2xs.clip & (e_reg[3].op == OP_M2MUL));

        e_next[5]      = e_reg[4];
        e_next[5].prod = 64'($signed(e_reg[4].oms)) * 64'($signed(e_reg[4].s));

        m2s           = sat64($signed(e_reg[5].prod) >>> FRAC_BITS);
        e_next[6]     = e_reg[5];
        e_next[6].m2  = m2s.val;
        e_next[6].sat = e_reg[5].sat | (m2s.clip & (e_reg[5].op == OP_OMS_MUL));
    end

    // Value selection ahead of the derivative divider.
    always_comb
    begin
        f_next       = '0;
        f_next.deriv = e_reg[E_STAGES].deriv;
        f_next.bad   = e_reg[E_STAGES].bad;
        f_next.degen = e_reg[E_STAGES].degen;
        f_next.sat   = e_reg[E_STAGES].sat;
        case (e_reg[E_STAGES].op)
            OP_CONST, OP_HALF, OP_SHIFT, OP_M2P: f_next.val = e_reg[E_STAGES].lin;
            OP_MUL_HALF, OP_PSI:                 f_next.val = e_reg[E_STAGES].m1;
            OP_OMS:                              f_next.val = e_reg[E_STAGES].oms;
            OP_M2MUL:                            f_next.val = e_reg[E_STAGES].m2x;
            OP_OMS_MUL:                          f_next.val = e_reg[E_STAGES].m2;
            default:                             f_next.val = '0;
        endcase
        d2_num = NUM_W'(f_next.val);
        d2_den = e_reg[E_STAGES].use_hy ? e_reg[E_STAGES].hy : e_reg[E_STAGES].hx;
    end

    // Derivative divider: reference derivative over the signed width.
    reb_qdiv u_div_deriv (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (e_vld_reg[E_STAGES]),
        .num     (d2_num),
        .den     (d2_den),
        .out_vld (d2_vld),
        .quo     (d2_quo),
        .clip    (d2_clip)
    );

    // Result assembly: special cases force zero and clear the clip flag.
    always_comb
    begin
        if (f_reg[DIV_LAT-1].bad || f_reg[DIV_LAT-1].degen)
        begin
            out_value_next = '0;
            out_sat_next   = 1'b0;
        end
        else if (f_reg[DIV_LAT-1].deriv)
        begin
            out_value_next = d2_quo;
            out_sat_next   = f_reg[DIV_LAT-1].sat | d2_clip;
        end
        else
        begin
            out_value_next = f_reg[DIV_LAT-1].val;
            out_sat_next   = f_reg[DIV_LAT-1].sat;
        end
    end

    // Valid bits of the top-level stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg   <= 1'b0;
            e_vld_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_vld_reg    <= in_valid;
            e_vld_reg[1] <= d1x_vld & d1y_vld;
            for (int i = 2; i <= E_STAGES; i++)
                e_vld_reg[i] <= e_vld_reg[i-1];
            out_vld_reg <= d2_vld;
        end
    end

    // Payload registers of the top-level stages and side lines.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_side_reg <= p_side_next;
            p_nx_reg   <= p_nx_next;
            p_ny_reg   <= p_ny_next;
            sd_reg[0]  <= p_side_reg;
            for (int i = 1; i < DIV_LAT; i++)
                sd_reg[i] <= sd_reg[i-1];
            for (int i = 1; i <= E_STAGES; i++)
                e_reg[i] <= e_next[i];
            f_reg[0] <= f_next;
            for (int i = 1; i < DIV_LAT; i++)
                f_reg[i] <= f_reg[i-1];
            out_value_reg <= out_value_next;
            out_sat_reg   <= out_sat_next;
            out_degen_reg <= f_reg[DIV_LAT-1].degen;
            out_bad_reg   <= f_reg[DIV_LAT-1].bad;
        end
    end

    assign out_valid   = out_vld_reg;
    assign basis_value = out_value_reg;
    assign degenerate  = out_degen_reg;
    assign bad_index   = out_bad_reg;
    assign saturated   = out_sat_reg;

endmodule

`default_nettype wire

[hw/rtl/reb_check.sv]
// Port-level assertions for the rectangular element basis evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module reb_check (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [2:0]         command,
    input logic [3:0]         basis_index,
    input logic signed [31:0] point_x,
    input logic signed [31:0] point_y,
    input logic signed [31:0] left_edge,
    input logic signed [31:0] right_edge,
    input logic signed [31:0] bottom_edge,
    input logic signed [31:0] top_edge,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] basis_value,
    input logic               degenerate,
    input logic               bad_index,
    input logic               saturated
);

    // A bad index gives a zero value with no clip.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_index |-> basis_value == 32'sd0 && !saturated)
        else $error("bad index result is not zero");

    // A degenerate element gives a zero value with no clip.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> basis_value == 32'sd0 && !saturated)
        else $error("degenerate result is not zero");

    // The input side is only held back by a waiting result.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result waiting");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(basis_value) && $stable(saturated))
        else $error("stalled result changed");

    // A stalled input item holds until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(command) && $stable(basis_index) &&
            $stable(point_x) && $stable(point_y) && $stable(left_edge) &&
            $stable(right_edge) && $stable(bottom_edge) && $stable(top_edge))
        else $error("stalled input item changed");

endmodule

bind rect_element_basis_eval reb_check u_reb_check (.*);

`default_nettype wire

[sim/rect_element_basis_eval_tb.sv]
// Self-checking testbench of the rectangular element basis evaluator.
`timescale 1ns / 1ps
`default_nettype none

module rect_element_basis_eval_tb;
    import reb_pkg::*;

    localparam int PIPE_LAT = 74;

    // One evaluation result.
    typedef struct {
        logic signed [31:0] value;
        logic               degen;
        logic               bad;
        logic               sat;
    } basis_res_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         command;
    logic [3:0]         basis_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] left_edge;
    logic signed [31:0] right_edge;
    logic signed [31:0] bottom_edge;
    logic signed [31:0] top_edge;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] basis_value;
    logic               degenerate;
    logic               bad_index;
    logic               saturated;

    basis_res_t expected_q[$];
    int         errors;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_cycles;

    // Working state of the predictor for one item.
    logic                clip_seen;
    longint              ksi_q;
    longint              etta_q;
    bit                  ksi_clipped;
    bit                  etta_clipped;

    rect_element_basis_eval dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .basis_index(basis_index),
        .point_x(point_x), .point_y(point_y),
        .left_edge(left_edge), .right_edge(right_edge),
        .bottom_edge(bottom_edge), .top_edge(top_edge),
        .out_valid(out_valid), .out_stall(out_stall),
        .basis_value(basis_value), .degenerate(degenerate),
        .bad_index(bad_index), .saturated(saturated)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Fixed-point helpers of the predictor.
    function automatic longint floor_sh(input longint p, input int n);
        return p >>> n;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            clip_seen = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            clip_seen = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Quotient (num << FRAC_BITS) / den, truncated, magnitude clamped.
    function automatic longint scaled_quot(input longint num, input longint den,
                                           output bit clip);
        longint unsigned an;
        longint unsigned ad;
        longint unsigned q;
        bit neg;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        clip = 1'b0;
        if (ad == 0)
            return 0;
        if (an >= (ad << (31 - FRAC_BITS)))
        begin
            clip = 1'b1;
            q = 64'h7FFFFFFF;
        end
        else
        begin
            q = (an << FRAC_BITS) / ad;
            if (q > 64'h7FFFFFFF)
            begin
                clip = 1'b1;
                q = 64'h7FFFFFFF;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint read_ksi();
        if (ksi_clipped)
            clip_seen = 1'b1;
        return ksi_q;
    endfunction

    function automatic longint read_etta();
        if (etta_clipped)
            clip_seen = 1'b1;
        return etta_q;
    endfunction

    function automatic longint qprod(input longint a, input longint b);
        return clamp32(floor_sh(a * b, FRAC_BITS));
    endfunction

    function automatic longint lo_half(input longint v);
        return floor_sh((64'sd1 << FRAC_BITS) - v, 1);
    endfunction

    function automatic longint hi_half(input longint v);
        return floor_sh((64'sd1 << FRAC_BITS) + v, 1);
    endfunction

    function automatic longint bubble(input longint v);
        return clamp32((64'sd1 << FRAC_BITS) - qprod(v, v));
    endfunction

    // Predicts the result of one item.
    function automatic basis_res_t predict_basis(
        input logic [2:0] cmd, input logic [3:0] idx,
        input longint px, input longint py, input longint xl, input longint xr,
        input longint yl, input longint yu);
        basis_res_t r;
        longint hx;
        longint hy;
        longint v;
        longint d;
        bit c;
        hx = xr - xl;
        hy = yu - yl;
        clip_seen = 1'b0;
        v = 0;
        r.bad = cmd > CMD_PSI || (cmd == CMD_PSI ? idx >= SCALAR_FUNCS : idx >= VECTOR_FUNCS);
        r.degen = (hx == 0) || (hy == 0);
        if (!r.bad && !r.degen)
        begin
            ksi_q = scaled_quot(2 * px - xl - xr, hx, ksi_clipped);
            etta_q = scaled_quot(2 * py - yl - yu, hy, etta_clipped);
            case (cmd)
                CMD_PHIX:
                    case (idx)
                        0: v = lo_half(read_ksi());
                        1: v = hi_half(read_ksi());
                        4: v = qprod(lo_half(read_ksi()), read_etta());
                        5: v = qprod(hi_half(read_ksi()), read_etta());
                        8: v = bubble(read_ksi());
                        9: v = qprod(bubble(read_ksi()), read_etta());
                        default: v = 0;
                    endcase
                CMD_PHIY:
                    case (idx)
                        2: v = lo_half(read_etta());
                        3: v = hi_half(read_etta());
                        6: v = qprod(lo_half(read_etta()), read_ksi());
                        7: v = qprod(hi_half(read_etta()), read_ksi());
                        10: v = bubble(read_etta());
                        11: v = qprod(bubble(read_etta()), read_ksi());
                        default: v = 0;
                    endcase
                CMD_DXK:
                begin
                    case (idx)
                        0: d = -(64'sd1 << (FRAC_BITS - 1));
                        1: d = 64'sd1 << (FRAC_BITS - 1);
                        4: d = floor_sh(-read_etta(), 1);
                        5: d = floor_sh(read_etta(), 1);
                        8: d = clamp32(-2 * read_ksi());
                        9: d = clamp32(-2 * qprod(read_ksi(), read_etta()));
                        default: d = 0;
                    endcase
                    v = scaled_quot(d, hx, c);
                    if (c)
                        clip_seen = 1'b1;
                end
                CMD_DYE:
                begin
                    case (idx)
                        2: d = -(64'sd1 << (FRAC_BITS - 1));
                        3: d = 64'sd1 << (FRAC_BITS - 1);
                        6: d = floor_sh(-read_ksi(), 1);
                        7: d = floor_sh(read_ksi(), 1);
                        10: d = clamp32(-2 * read_etta());
                        11: d = clamp32(-2 * qprod(read_etta(), read_ksi()));
                        default: d = 0;
                    endcase
                    v = scaled_quot(d, hy, c);
                    if (c)
                        clip_seen = 1'b1;
                end
                default:
                    case (idx)
                        0: v = qprod(lo_half(read_ksi()), lo_half(read_etta()));
                        1: v = qprod(hi_half(read_ksi()), lo_half(read_etta()));
                        2: v = qprod(lo_half(read_ksi()), hi_half(read_etta()));
                        default: v = qprod(hi_half(read_ksi()), hi_half(read_etta()));
                    endcase
            endcase
            v = clamp32(v);
        end
        else
        begin
            clip_seen = 1'b0;
        end
        r.value = 32'(v);
        r.sat = clip_seen;
        return r;
    endfunction

    // Prints one mismatch and counts it.
    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    // Sends one item and queues its expected result once accepted.
    task automatic send_item(input logic [2:0] cmd, input logic [3:0] idx,
                             input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] xl, input logic signed [31:0] xr,
                             input logic signed [31:0] yl, input logic signed [31:0] yu);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        basis_index <= idx;
        point_x     <= px;
        point_y     <= py;
        left_edge   <= xl;
        right_edge  <= xr;
        bottom_edge <= yl;
        top_edge    <= yu;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(predict_basis(cmd, idx, px, py, xl, xr, yl, yu));
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        go_quiet();
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Random item: mostly sensible elements, some wild values.
    task automatic send_random_item();
        logic signed [31:0] xl;
        logic signed [31:0] yl;
        logic signed [31:0] w;
        logic signed [31:0] h;
        logic [2:0] cmd;
        logic [3:0] idx;
        cmd = $urandom_range(9) == 0 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        idx = $urandom_range(9) == 0 ? 4'($urandom) :
              (cmd == CMD_PSI ? 4'($urandom_range(3)) : 4'($urandom_range(11)));
        if ($urandom_range(4) == 0)
        begin
            send_item(cmd, idx, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        end
        else
        begin
            xl = $signed($urandom_range(2000000)) - 1000000;
            yl = $signed($urandom_range(2000000)) - 1000000;
            w = $urandom_range(19) == 0 ? 0 : $signed($urandom_range(400000)) - 200000;
            h = $urandom_range(19) == 0 ? 0 : $signed($urandom_range(400000)) - 200000;
            send_item(cmd, idx, xl + $signed($urandom_range(600000)) - 100000,
                      yl + $signed($urandom_range(600000)) - 100000, xl, xl + w, yl, yl + h);
        end
    endtask

    // Directed: every command with a random index, extremes and special elements.
    task automatic test_directed();
        for (int c = 0; c < 5; c++)
            send_item(3'(c), 4'($urandom_range(11)), 32'sh8000, 32'sh4000, 0, 32'sh10000,
                      0, 32'sh10000);
        send_item(CMD_PHIX, 4'd9, 32'sh18000, -32'sh8000, 0, 32'sh20000, -32'sh10000,
                  32'sh10000);
        send_item(CMD_DYE, 4'd11, 32'sh1000, 32'sh3000, 32'sh1000, 32'sh7000, 0, 32'sh4000);
        send_item(CMD_PSI, 4'd3, 32'sh5000, 32'sh6000, 0, 32'sh10000, 0, 32'sh10000);
        send_item(3'd7, 4'd0, 0, 0, 0, 32'sh10000, 0, 32'sh10000);
        send_item(CMD_PSI, 4'd4, 0, 0, 0, 32'sh10000, 0, 32'sh10000);
        send_item(CMD_PHIX, 4'd15, 0, 0, 0, 32'sh10000, 0, 32'sh10000);
        send_item(CMD_PHIX, 4'd0, 0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000);
        send_item(CMD_PHIY, 4'd2, 0, 0, 0, 32'sh10000, 5, 5);
        send_item(CMD_PHIX, 4'd2, 0, 0, 0, 32'sh10000, 0, 32'sh10000);
        send_item(CMD_PHIX, 4'd8, 32'sh7FFFFFFF, 0, 0, 1, 0, 32'sh10000);
        send_item(CMD_PHIY, 4'd10, 0, 32'sh80000000, 0, 1, 0, 1);
        send_item(CMD_DXK, 4'd8, 32'sh7FFFFFFF, 0, 32'sh80000000, 32'sh7FFFFFFF, 0, 1);
        send_item(CMD_DXK, 4'd1, 0, 0, 0, 1, 0, 1);
        send_item(CMD_DYE, 4'd3, 0, 0, 0, 1, 32'sh7FFFFFFF, 32'sh80000000);
        send_item(CMD_PSI, 4'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh10000, 0, 32'sh10000, 0);
        send_item(CMD_PHIY, 4'd7, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                  32'sh80000000, 32'sh7FFFFFFF);
        send_item(CMD_PHIY, 4'd3, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF,
                  32'shFFFFFFFF, 32'shFFFFFFFF);
        wait_drained();
    endtask

    // Random phase with given idle and stall rates.
    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n)
            send_random_item();
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        repeat (200)
            send_random_item();
        wait_drained();
    endtask

    // Receiver: random stall, plus an optional long hold counted here.
    initial
    begin
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                basis_res_t e;
                e = expected_q.pop_front();
                if (basis_value !== e.value)
                    report_mismatch($sformatf("basis_value %h expected %h",
                                              basis_value, e.value));
                if (degenerate !== e.degen)
                    report_mismatch($sformatf("degenerate %b expected %b", degenerate, e.degen));
                if (bad_index !== e.bad)
                    report_mismatch($sformatf("bad_index %b expected %b", bad_index, e.bad));
                if (saturated !== e.sat)
                    report_mismatch($sformatf("saturated %b expected %b", saturated, e.sat));
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = '0;
        basis_index = '0;
        point_x = '0;
        point_y = '0;
        left_edge = '0;
        right_edge = '0;
        bottom_edge = '0;
        top_edge = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400, 0, 0);
        test_random(300, 73, 0);
        test_random(300, 0, 73);
        test_random(300, 18, 18);
        test_backpressure();
        test_random(100, 0, 0);
        repeat (PIPE_LAT + 20) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS rect_element_basis_eval");
        else
            $display("FAIL rect_element_basis_eval");
        $finish;
    end

    // Run time limit.
    initial
    begin
        #5000000;
        $display("FAIL rect_element_basis_eval");
        $finish;
    end

endmodule

`default_nettype wire
